// File: hdl/assert_macros.svh
// Assertion helpers used by stereo_feedback_delay.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SFD_ASSERT_IMP(lbl, pre, post, msg) \
  `SFD_ASSERT(lbl, (pre) |-> (post), msg)

`define SFD_ASSERT_NEXT(lbl, pre, post, msg) \
  `SFD_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// File: hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 131072;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_SYNC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_DIV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd6;

  // Register reset values.
  localparam logic [10:0] TIME_MS_RST  = 11'd375;
  localparam logic [14:0] FEEDBACK_RST = 15'd13107;
  localparam logic [15:0] WET_MIX_RST  = 16'd13107;
  localparam logic [2:0]  NOTE_DIV_RST = 3'd3;
  localparam logic [8:0]  BPM_RST      = 9'd120;
  localparam logic [17:0] RATE_RST     = 18'd48000;

  // Limits applied to the register values.
  localparam logic [10:0] TIME_MIN = 11'd10;
  localparam logic [10:0] TIME_MAX = 11'd2000;
  localparam logic [14:0] FB_MAX   = 15'd31129;
  localparam logic [15:0] WET_MAX  = 16'd32768;
  localparam logic [8:0]  BPM_MIN  = 9'd20;
  localparam logic [8:0]  BPM_MAX  = 9'd300;

  localparam logic [16:0] ONE_Q15  = 17'd32768;
  localparam int          HALF_LSB = 16384;
  localparam int          Q_SHIFT  = 15;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  // Delay length divider: numerator up to 2000 * 262143, divisor up to 1000.
  localparam int unsigned NUM_W = 29;
  localparam int unsigned DEN_W = 10;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    DC_LOAD,
    DC_DIV,
    DC_DONE
  } dc_state_e;

  // Five times the note length in twelfths of a beat. Code seven acts as six.
  function automatic logic [7:0] beat_factor(input logic [2:0] note_div);
    logic [7:0] f;
    case (note_div)
      3'd0:    f = 8'd240;
      3'd1:    f = 8'd120;
      3'd2:    f = 8'd60;
      3'd3:    f = 8'd30;
      3'd4:    f = 8'd15;
      3'd5:    f = 8'd20;
      default: f = 8'd90;
    endcase
    return f;
  endfunction

endpackage

// File: hdl/sfd_ram.sv
module sfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/stereo_feedback_delay.sv
// Channel   Handshake               Payload
// input     in_valid_i/in_ready_o   in_left_i, in_right_i
// output    out_valid_o/out_ready_i out_left_o, out_right_o
// config    cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One item per cycle unless stalled or dividing; each result passes s1, s2, then out_v_q.
// The delay lines are one RAM per channel, read once and written once per item.
// After reset and after every register write, a bit-serial divider works out
// the delay length in states DC_LOAD and DC_DIV; no item is taken meanwhile.
// The delay lines need no clearing pass: entries not yet written read as zero.
// A stalled output fills the three pipeline stages before ready drops.
module stereo_feedback_delay #(
  parameter int unsigned DEPTH       = sfd_pkg::DEPTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             in_left_i,
  input  logic signed [15:0]             in_right_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             out_left_o,
  output logic signed [15:0]             out_right_o
);

  import sfd_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int          SB = SAMPLE_BITS;
  localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [NUM_W-1:0] Q_MAX = NUM_W'(DEPTH - 1);

  // Feedback path widths.
  localparam int FPW = SB + 16;
  localparam int FW  = ((SB + 2) > 16 ? (SB + 2) : 16) + 1;
  localparam longint SMAX_L = (longint'(1) <<< (SB - 1)) - 1;
  localparam logic signed [FW-1:0] S_HI = FW'(SMAX_L);
  localparam logic signed [FW-1:0] S_LO = FW'(-SMAX_L - 1);

  // Output mix widths.
  localparam int WPW = SB + 17;
  localparam int DPW = 33;
  localparam int MW  = ((WPW > DPW) ? WPW : DPW) + 2;
  localparam logic signed [MW-Q_SHIFT-1:0] O_HI = (MW - Q_SHIFT)'(32767);
  localparam logic signed [MW-Q_SHIFT-1:0] O_LO = (MW - Q_SHIFT)'(-32768);

  // ---------------------------------------------------------------- registers
  logic [10:0] time_ms_q;
  logic [14:0] fb_q;
  logic [15:0] wet_q;
  logic        sync_q;
  logic [2:0]  div_q;
  logic [8:0]  bpm_q;
  logic [17:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_ms_q <= TIME_MS_RST;
      fb_q      <= FEEDBACK_RST;
      wet_q     <= WET_MIX_RST;
      sync_q    <= 1'b0;
      div_q     <= NOTE_DIV_RST;
      bpm_q     <= BPM_RST;
      rate_q    <= RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_MS:     time_ms_q <= cfg_data_i[10:0];
        CFG_FEEDBACK:    fb_q      <= cfg_data_i[14:0];
        CFG_WET_MIX:     wet_q     <= cfg_data_i[15:0];
        CFG_TEMPO_SYNC:  sync_q    <= cfg_data_i[0];
        CFG_NOTE_DIV:    div_q     <= cfg_data_i[2:0];
        CFG_TEMPO_BPM:   bpm_q     <= cfg_data_i[8:0];
        CFG_SAMPLE_RATE: rate_q    <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  logic [10:0] time_c;
  logic [8:0]  bpm_c;
  logic [14:0] fb_c;
  logic [15:0] wet_c;
  logic [15:0] dry_c;

  always_comb begin
    time_c = (time_ms_q < TIME_MIN) ? TIME_MIN :
             (time_ms_q > TIME_MAX) ? TIME_MAX : time_ms_q;
    bpm_c  = (bpm_q < BPM_MIN) ? BPM_MIN : (bpm_q > BPM_MAX) ? BPM_MAX : bpm_q;
    fb_c   = (fb_q > FB_MAX) ? FB_MAX : fb_q;
    wet_c  = (wet_q > WET_MAX) ? WET_MAX : wet_q;
    dry_c  = 16'(ONE_Q15 - {1'b0, wet_c});
  end

  // ------------------------------------------------------ delay length unit
  dc_state_e        dc_state_q, dc_state_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             dc_load, dc_step, dly_ok;
  logic [NUM_W-1:0] num_load;
  logic [DEN_W-1:0] den_load;
  logic [DEN_W:0]   trial, trial_diff;
  logic             trial_ge;
  logic [AW-1:0]    dly_len;

  always_comb begin
    dc_state_d = dc_state_q;
    if (cfg_we_i) begin
      dc_state_d = DC_LOAD;
    end else begin
      case (dc_state_q)
        DC_LOAD: dc_state_d = DC_DIV;
        DC_DIV:  dc_state_d = (cnt_q == CNT_W'(NUM_W - 1)) ? DC_DONE : DC_DIV;
        DC_DONE: dc_state_d = DC_DONE;
        default: dc_state_d = DC_LOAD;
      endcase
    end
  end

  always_comb begin
    dc_load = 1'b0;
    dc_step = 1'b0;
    dly_ok  = 1'b0;
    case (dc_state_q)
      DC_LOAD: dc_load = 1'b1;
      DC_DIV:  dc_step = 1'b1;
      DC_DONE: dly_ok  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_state_q <= DC_LOAD;
      cnt_q      <= '0;
    end else begin
      dc_state_q <= dc_state_d;
      if (dc_load) begin
        cnt_q <= '0;
      end else if (dc_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    num_load = sync_q ? (NUM_W'(rate_q) * NUM_W'(beat_factor(div_q)))
                      : (NUM_W'(time_c) * NUM_W'(rate_q));
    den_load = sync_q ? DEN_W'(bpm_c) : MS_PER_S;
    // Restoring division, one quotient bit per cycle shifted into num_q.
    trial      = {rem_q, num_q[NUM_W-1]};
    trial_diff = trial - {1'b0, den_q};
    trial_ge   = (trial >= {1'b0, den_q});
    rem_d      = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d      = {num_q[NUM_W-2:0], trial_ge};
  end

  always_ff @(posedge clk_i) begin
    if (dc_load) begin
      num_q <= num_load;
      den_q <= den_load;
      rem_q <= '0;
    end else if (dc_step) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    if (num_q == '0) begin
      dly_len = AW'(1);
    end else if (num_q > Q_MAX) begin
      dly_len = WP_LAST;
    end else begin
      dly_len = num_q[AW-1:0];
    end
  end

  // ---------------------------------------------------------------- pipeline
  logic          adv0, adv1, adv2;
  logic          in_fire;
  logic          s1_v_q, s2_v_q, out_v_q;
  logic [AW-1:0] wp_q;
  logic          wrapped_q;
  logic [AW:0]   rp_diff, rp_sum;
  logic [AW-1:0] rp;
  logic          rd_zero, rd_fwd, mem_we;
  logic [AW-1:0] s1_wp_q;
  logic          s1_fwd_q, s1_zero_q;

  assign adv2       = !out_v_q || out_ready_i;
  assign adv1       = !s2_v_q || adv2;
  assign adv0       = !s1_v_q || adv1;
  assign in_ready_o = adv0 && dly_ok;
  assign in_fire    = in_valid_i && in_ready_o;
  assign mem_we     = s1_v_q && adv1;

  always_comb begin
    rp_diff = {1'b0, wp_q} - {1'b0, dly_len};
    rp_sum  = rp_diff + DEPTH_W;
    rp      = rp_diff[AW] ? rp_sum[AW-1:0] : rp_diff[AW-1:0];
    // Entries are first written in address order, so before the pointer wraps
    // everything at or above it is still unwritten and is read as zero.
    rd_zero = !wrapped_q && (rp >= wp_q);
    // The entry being written in this cycle is forwarded when the item behind it reads it.
    rd_fwd  = mem_we && (rp == s1_wp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (wp_q == WP_LAST) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
      end
      if (adv0) begin
        s1_v_q <= in_fire;
      end
      if (adv1) begin
        s2_v_q <= s1_v_q;
      end
      if (adv2) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_wp_q   <= wp_q;
      s1_fwd_q  <= rd_fwd;
      s1_zero_q <= rd_zero;
    end
  end

  logic signed [15:0] x_in [2];
  logic signed [15:0] y_out [2];

  assign x_in[0] = in_left_i;
  assign x_in[1] = in_right_i;

  for (genvar c = 0; c < 2; c++) begin : g_chan
    logic signed [15:0]        s1_x_q;
    logic signed [SB-1:0]      fwd_q;
    logic [SB-1:0]             rdata;
    logic signed [SB-1:0]      dly;
    logic signed [FPW-1:0]     fb_prod;
    logic signed [FPW:0]       fb_round;
    logic signed [FW-1:0]      fb_sum;
    logic signed [SB-1:0]      wv;
    logic signed [WPW-1:0]     wet_prod;
    logic signed [DPW-1:0]     dry_prod;
    logic signed [WPW-1:0]     s2_wet_q;
    logic signed [DPW-1:0]     s2_dry_q;
    logic signed [MW-1:0]      mix;
    logic signed [MW-Q_SHIFT-1:0] mix_q15;
    logic signed [15:0]        y_q;

    sfd_ram #(
      .WIDTH (SB),
      .DEPTH (DEPTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (s1_wp_q),
      .wdata_i (wv),
      .re_i    (in_fire),
      .raddr_i (rp),
      .rdata_o (rdata)
    );

    always_comb begin
      if (s1_fwd_q) begin
        dly = fwd_q;
      end else if (s1_zero_q) begin
        dly = '0;
      end else begin
        dly = $signed(rdata);
      end
      fb_prod  = FPW'(dly) * FPW'($signed({1'b0, fb_c}));
      fb_round = (FPW + 1)'(fb_prod) + (FPW + 1)'(HALF_LSB);
      fb_sum   = FW'($signed(fb_round[FPW:Q_SHIFT])) + FW'(s1_x_q);
      if (fb_sum > S_HI) begin
        wv = SB'(S_HI);
      end else if (fb_sum < S_LO) begin
        wv = SB'(S_LO);
      end else begin
        wv = fb_sum[SB-1:0];
      end
      wet_prod = WPW'(dly) * WPW'($signed({1'b0, wet_c}));
      dry_prod = DPW'(s1_x_q) * DPW'($signed({1'b0, dry_c}));
    end

    always_comb begin
      mix     = MW'(s2_wet_q) + MW'(s2_dry_q) + MW'(HALF_LSB);
      mix_q15 = mix[MW-1:Q_SHIFT];
    end

    always_ff @(posedge clk_i) begin
      if (in_fire) begin
        s1_x_q <= x_in[c];
      end
      if (mem_we) begin
        fwd_q    <= wv;
        s2_wet_q <= wet_prod;
        s2_dry_q <= dry_prod;
      end
      if (s2_v_q && adv2) begin
        if (mix_q15 > O_HI) begin
          y_q <= 16'sh7fff;
        end else if (mix_q15 < O_LO) begin
          y_q <= -16'sh8000;
        end else begin
          y_q <= mix_q15[15:0];
        end
      end
    end

    assign y_out[c] = y_q;
  end

  assign out_valid_o = out_v_q;
  assign out_left_o  = y_out[0];
  assign out_right_o = y_out[1];

  // ---------------------------------------------------------------- checks
  `SFD_ASSERT_IMP(a_dly_range, dly_ok, (dly_len != '0) && ((AW + 1)'(dly_len) < DEPTH_W), "delay length out of range")
  `SFD_ASSERT_NEXT(a_wp_step, in_fire && (wp_q != WP_LAST), wp_q == $past(wp_q) + 1'b1, "write pointer skipped")
  `SFD_ASSERT_NEXT(a_cfg_block, cfg_we_i, !in_ready_o, "item taken while delay length is stale")
  `SFD_ASSERT_NEXT(a_out_load, s2_v_q && adv2, out_valid_o, "finished item not presented")

endmodule
